### design/lr_pkg.sv
`default_nettype none

package lr_pkg;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'd0,
        MODE_OCT1  = 4'd1,
        MODE_OCT2  = 4'd2,
        MODE_OCT3  = 4'd3,
        MODE_OCT4  = 4'd4,
        MODE_OCT5  = 4'd5,
        MODE_OCT6  = 4'd6,
        MODE_OCT7  = 4'd7,
        MODE_OCT8  = 4'd8,
        MODE_POS_X = 4'd9,
        MODE_NEG_X = 4'd10,
        MODE_POS_Y = 4'd11,
        MODE_NEG_Y = 4'd12
    } mode_t;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    typedef struct packed {
        logic will_emit;
        logic last;
    } step_ctl_t;

endpackage

`default_nettype wire

### design/lr_in_reg.sv
`default_nettype none

module lr_in_reg #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire logic                  kind,
    input  wire logic [COORD_BITS-1:0] from_x,
    input  wire logic [COORD_BITS-1:0] from_y,
    input  wire logic [COORD_BITS-1:0] to_x,
    input  wire logic [COORD_BITS-1:0] to_y,
    input  wire logic                  fire,
    output logic                       held_valid,
    output logic                       held_kind,
    output logic [COORD_BITS-1:0]      held_from_x,
    output logic [COORD_BITS-1:0]      held_from_y,
    output logic [COORD_BITS-1:0]      held_to_x,
    output logic [COORD_BITS-1:0]      held_to_y
);

    logic                  valid_reg, valid_next;
    logic                  kind_reg;
    logic [COORD_BITS-1:0] from_x_reg, from_y_reg, to_x_reg, to_y_reg;
    logic                  take;

    assign item_ready = !valid_reg || fire;
    assign take       = item_valid && item_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg   <= kind;
            from_x_reg <= from_x;
            from_y_reg <= from_y;
            to_x_reg   <= to_x;
            to_y_reg   <= to_y;
        end
    end

    assign held_valid  = valid_reg;
    assign held_kind   = kind_reg;
    assign held_from_x = from_x_reg;
    assign held_from_y = from_y_reg;
    assign held_to_x   = to_x_reg;
    assign held_to_y   = to_y_reg;

endmodule

`default_nettype wire

### design/lr_step.sv
`default_nettype none

module lr_step #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  fire,
    input  wire logic                  kind,
    input  wire logic [COORD_BITS-1:0] from_x,
    input  wire logic [COORD_BITS-1:0] from_y,
    input  wire logic [COORD_BITS-1:0] to_x,
    input  wire logic [COORD_BITS-1:0] to_y,
    output lr_pkg::step_ctl_t          ctl,
    output logic [COORD_BITS-1:0]      pix_x,
    output logic [COORD_BITS-1:0]      pix_y
);

    import lr_pkg::*;

    localparam int D_W   = COORD_BITS + 2;
    localparam int ERR_W = COORD_BITS + 3;
    localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

    logic                    busy_reg, busy_next;
    mode_t                   mode_reg, mode_next;
    logic [COORD_BITS-1:0]   cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0]   goal_x_reg, goal_x_next, goal_y_reg, goal_y_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic signed [ERR_W-1:0] tdx_reg, tdx_next, tdy_reg, tdy_next;

    logic signed [D_W-1:0]   dx, dy, ndx, ndy;
    logic                    dx_zero, dy_zero, dx_pos, dy_pos;
    mode_t                   start_mode;
    logic signed [ERR_W-1:0] start_err;

    logic [COORD_BITS-1:0]   nx, ny;
    logic signed [ERR_W-1:0] err_a, err_b, ne;
    logic                    done, minor;
    logic                    stepping, starting;

    // start: deltas and direction select
    assign dx      = $signed({2'b00, to_x}) - $signed({2'b00, from_x});
    assign dy      = $signed({2'b00, to_y}) - $signed({2'b00, from_y});
    assign ndx     = -dx;
    assign ndy     = -dy;
    assign dx_zero = (dx == '0);
    assign dy_zero = (dy == '0);
    assign dx_pos  = !dx[D_W-1] && !dx_zero;
    assign dy_pos  = !dy[D_W-1] && !dy_zero;

    always_comb
    begin
        start_mode = MODE_IDLE;
        if (dx_zero && dy_zero)
        begin
            start_mode = MODE_IDLE;
        end
        else if (dy_zero)
        begin
            start_mode = dx_pos ? MODE_POS_X : MODE_NEG_X;
        end
        else if (dx_zero)
        begin
            start_mode = dy_pos ? MODE_POS_Y : MODE_NEG_Y;
        end
        else if (dx_pos && dy_pos)
        begin
            start_mode = (dx >= dy) ? MODE_OCT1 : MODE_OCT2;
        end
        else if (dx_pos)
        begin
            start_mode = (dx >= ndy) ? MODE_OCT8 : MODE_OCT7;
        end
        else if (dy_pos)
        begin
            start_mode = (ndx >= dy) ? MODE_OCT4 : MODE_OCT3;
        end
        else
        begin
            start_mode = (dx <= dy) ? MODE_OCT5 : MODE_OCT6;
        end
    end

    always_comb
    begin
        unique case (start_mode)
            MODE_OCT1, MODE_OCT4, MODE_OCT5, MODE_OCT8:
            begin
                start_err = ERR_W'(dx);
            end
            MODE_OCT2, MODE_OCT3, MODE_OCT6, MODE_OCT7:
            begin
                start_err = ERR_W'(dy);
            end
            default:
            begin
                start_err = '0;
            end
        endcase
    end

    // step: major axis always moves, minor axis on the error test
    always_comb
    begin
        nx    = cur_x_reg;
        ny    = cur_y_reg;
        err_a = err_reg;
        err_b = err_reg;
        minor = 1'b0;
        done  = 1'b0;
        unique case (mode_reg)
            MODE_OCT1:
            begin
                nx    = cur_x_reg + ONE;
                done  = (nx == goal_x_reg);
                err_a = err_reg - tdy_reg;
                minor = err_a[ERR_W-1];
                err_b = err_a + tdx_reg;
                if (minor)
                begin
                    ny = cur_y_reg + ONE;
                end
            end
            MODE_OCT2:
            begin
                ny    = cur_y_reg + ONE;
                done  = (ny == goal_y_reg);
                err_a = err_reg - tdx_reg;
                minor = err_a[ERR_W-1];
                err_b = err_a + tdy_reg;
                if (minor)
                begin
                    nx = cur_x_reg + ONE;
                end
            end
            MODE_OCT3:
            begin
                ny    = cur_y_reg + ONE;
                done  = (ny == goal_y_reg);
                err_a = err_reg + tdx_reg;
                minor = err_a[ERR_W-1] || (err_a == '0);
                err_b = err_a + tdy_reg;
                if (minor)
                begin
                    nx = cur_x_reg - ONE;
                end
            end
            MODE_OCT4:
            begin
                nx    = cur_x_reg - ONE;
                done  = (nx == goal_x_reg);
                err_a = err_reg + tdy_reg;
                minor = !err_a[ERR_W-1];
                err_b = err_a + tdx_reg;
                if (minor)
                begin
                    ny = cur_y_reg + ONE;
                end
            end
            MODE_OCT5:
            begin
                nx    = cur_x_reg - ONE;
                done  = (nx == goal_x_reg);
                err_a = err_reg - tdy_reg;
                minor = !err_a[ERR_W-1];
                err_b = err_a + tdx_reg;
                if (minor)
                begin
                    ny = cur_y_reg - ONE;
                end
            end
            MODE_OCT6:
            begin
                ny    = cur_y_reg - ONE;
                done  = (ny == goal_y_reg);
                err_a = err_reg - tdx_reg;
                minor = !err_a[ERR_W-1];
                err_b = err_a + tdy_reg;
                if (minor)
                begin
                    nx = cur_x_reg - ONE;
                end
            end
            MODE_OCT7:
            begin
                ny    = cur_y_reg - ONE;
                done  = (ny == goal_y_reg);
                err_a = err_reg + tdx_reg;
                minor = !err_a[ERR_W-1] && (err_a != '0);
                err_b = err_a + tdy_reg;
                if (minor)
                begin
                    nx = cur_x_reg + ONE;
                end
            end
            MODE_OCT8:
            begin
                nx    = cur_x_reg + ONE;
                done  = (nx == goal_x_reg);
                err_a = err_reg + tdy_reg;
                minor = err_a[ERR_W-1];
                err_b = err_a + tdx_reg;
                if (minor)
                begin
                    ny = cur_y_reg - ONE;
                end
            end
            MODE_POS_X:
            begin
                nx   = cur_x_reg + ONE;
                done = (nx == goal_x_reg);
            end
            MODE_NEG_X:
            begin
                nx   = cur_x_reg - ONE;
                done = (nx == goal_x_reg);
            end
            MODE_POS_Y:
            begin
                ny   = cur_y_reg + ONE;
                done = (ny == goal_y_reg);
            end
            MODE_NEG_Y:
            begin
                ny   = cur_y_reg - ONE;
                done = (ny == goal_y_reg);
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
        ne = minor ? err_b : err_a;
    end

    assign stepping = fire && (kind == KIND_STEP) && busy_reg;
    assign starting = fire && (kind == KIND_START);

    always_comb
    begin
        busy_next   = busy_reg;
        mode_next   = mode_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        goal_x_next = goal_x_reg;
        goal_y_next = goal_y_reg;
        err_next    = err_reg;
        tdx_next    = tdx_reg;
        tdy_next    = tdy_reg;
        if (starting)
        begin
            cur_x_next  = from_x;
            cur_y_next  = from_y;
            goal_x_next = to_x;
            goal_y_next = to_y;
            tdx_next    = ERR_W'(dx) <<< 1;
            tdy_next    = ERR_W'(dy) <<< 1;
            err_next    = start_err;
            mode_next   = start_mode;
            busy_next   = (start_mode != MODE_IDLE);
        end
        else if (stepping)
        begin
            cur_x_next = nx;
            cur_y_next = ny;
            if (done)
            begin
                busy_next = 1'b0;
                mode_next = MODE_IDLE;
            end
            else
            begin
                err_next = ne;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            mode_reg   <= MODE_IDLE;
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            err_reg    <= '0;
            tdx_reg    <= '0;
            tdy_reg    <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            mode_reg   <= mode_next;
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            goal_x_reg <= goal_x_next;
            goal_y_reg <= goal_y_next;
            err_reg    <= err_next;
            tdx_reg    <= tdx_next;
            tdy_reg    <= tdy_next;
        end
    end

    assign ctl.will_emit = (kind == KIND_STEP) && busy_reg;
    assign ctl.last      = done;
    assign pix_x         = cur_x_reg;
    assign pix_y         = cur_y_reg;

    a_busy_mode: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (mode_reg != MODE_IDLE))
        else $error("busy flag and direction mode disagree");

    a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (stepping && done) |=> !busy_reg)
        else $error("line still busy after its last pixel");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        starting |=> (busy_reg == ($past(from_x) != $past(to_x)
                                   || $past(from_y) != $past(to_y))))
        else $error("start beat loaded the wrong busy state");

endmodule

`default_nettype wire

### design/lr_out_reg.sv
`default_nettype none

module lr_out_reg #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire logic [COORD_BITS-1:0] load_x,
    input  wire logic [COORD_BITS-1:0] load_y,
    input  wire logic                  load_last,
    output logic                       slot_free,
    output logic                       pixel_valid,
    input  wire logic                  pixel_ready,
    output logic [COORD_BITS-1:0]      pixel_x,
    output logic [COORD_BITS-1:0]      pixel_y,
    output logic                       last
);

    logic                  valid_reg, valid_next;
    logic [COORD_BITS-1:0] x_reg, y_reg;
    logic                  last_reg;

    assign slot_free = !valid_reg || pixel_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (pixel_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg    <= load_x;
            y_reg    <= load_y;
            last_reg <= load_last;
        end
    end

    assign pixel_valid = valid_reg;
    assign pixel_x     = x_reg;
    assign pixel_y     = y_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

### design/line_rasterizer_top.sv
// a step beat is held in the input register, and its pixel is registered in the output register
// throughput: one beat per cycle, start or step, while pixel_ready stays high
// each step is two chained error adds, a sign test and the coordinate moves, all between registers
// a start beat and a step beat while idle produce no pixel
// reset (rst_n low, asynchronous) empties both registers and leaves no line active
`default_nettype none

module line_rasterizer_top #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire logic                  kind,
    input  wire logic [COORD_BITS-1:0] from_x,
    input  wire logic [COORD_BITS-1:0] from_y,
    input  wire logic [COORD_BITS-1:0] to_x,
    input  wire logic [COORD_BITS-1:0] to_y,
    output logic                       pixel_valid,
    input  wire logic                  pixel_ready,
    output logic [COORD_BITS-1:0]      pixel_x,
    output logic [COORD_BITS-1:0]      pixel_y,
    output logic                       last
);

    import lr_pkg::*;

    logic                  held_valid, held_kind;
    logic [COORD_BITS-1:0] held_from_x, held_from_y, held_to_x, held_to_y;
    step_ctl_t             ctl;
    logic [COORD_BITS-1:0] pix_x, pix_y;
    logic                  slot_free, fire, load;

    assign fire = held_valid && (slot_free || !ctl.will_emit);
    assign load = fire && ctl.will_emit;

    lr_in_reg #(
        .COORD_BITS(COORD_BITS)
    ) u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .kind       (kind),
        .from_x     (from_x),
        .from_y     (from_y),
        .to_x       (to_x),
        .to_y       (to_y),
        .fire       (fire),
        .held_valid (held_valid),
        .held_kind  (held_kind),
        .held_from_x(held_from_x),
        .held_from_y(held_from_y),
        .held_to_x  (held_to_x),
        .held_to_y  (held_to_y)
    );

    lr_step #(
        .COORD_BITS(COORD_BITS)
    ) u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .kind  (held_kind),
        .from_x(held_from_x),
        .from_y(held_from_y),
        .to_x  (held_to_x),
        .to_y  (held_to_y),
        .ctl   (ctl),
        .pix_x (pix_x),
        .pix_y (pix_y)
    );

    lr_out_reg #(
        .COORD_BITS(COORD_BITS)
    ) u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .load_x     (pix_x),
        .load_y     (pix_y),
        .load_last  (ctl.last),
        .slot_free  (slot_free),
        .pixel_valid(pixel_valid),
        .pixel_ready(pixel_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last       (last)
    );

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> pixel_valid)
        else $error("pixel computed but not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel_ready) |-> !load)
        else $error("pending pixel overwritten");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !held_valid |-> item_ready)
        else $error("input register empty but not ready");

endmodule

`default_nettype wire
